FILE: rtl/weighted_window_class_summary_top_macros.svh
// Assertion macros for the weighted window class summary block.
// Included by the top level; needs nothing else.
`ifndef WEIGHTED_WINDOW_CLASS_SUMMARY_TOP_MACROS_SVH
`define WEIGHTED_WINDOW_CLASS_SUMMARY_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WWCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wwcs assertion failed");

// Next-cycle implication, checked outside reset.
`define WWCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wwcs assertion failed");

`endif

FILE: rtl/wwcs_pkg.sv
// Shared types and constants for the weighted window class summary block.
// Used by every RTL module of the block; depends on nothing.
package wwcs_pkg;

    localparam int X_W     = 16;
    localparam int Y_W     = 16;
    localparam int WT_W    = 16;
    localparam int IDX_W   = 12;
    localparam int SKIP_W  = 13;
    localparam int WSUM_W  = 28;
    localparam int WYSUM_W = 43;
    localparam int CNT_W   = 13;
    localparam int PROD_W  = WT_W + Y_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 184;

    // Reset value of the skip register: minus one, nothing skipped.
    localparam logic [SKIP_W-1:0] SKIP_NONE = '1;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [Y_W-1:0]        y;
        logic [WT_W-1:0]       weight;
        logic [IDX_W-1:0]      index;
        logic                  last;
    } t_sample;

    typedef struct packed {
        logic signed [X_W-1:0] max_all;
        logic signed [X_W-1:0] min_all;
        logic                  saw_high;
        logic signed [X_W-1:0] max_high;
        logic signed [X_W-1:0] min_high;
        logic                  saw_low;
        logic signed [X_W-1:0] max_low;
        logic signed [X_W-1:0] min_low;
        logic [WSUM_W-1:0]     weight_sum;
        logic [WYSUM_W-1:0]    weighted_y_sum;
        logic [CNT_W-1:0]      point_count;
        logic                  separable;
    } t_summary;

endpackage

FILE: rtl/wwcs_accum.sv
// Running window state: extremes per class, weight sums and point count.
// Depends on wwcs_pkg; produces the finished summary on the closing beat.
module wwcs_accum
    import wwcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_sample           i_sample,
    input  logic [SKIP_W-1:0] i_skip_index,
    output t_summary          o_summary
);

    logic signed [X_W-1:0] r_max_all, r_min_all, r_max_high, r_min_high;
    logic signed [X_W-1:0] r_max_low, r_min_low;
    logic                  r_seen_high, r_seen_low;
    logic [WSUM_W-1:0]     r_wsum;
    logic [WYSUM_W-1:0]    r_wysum;
    logic [CNT_W-1:0]      r_count;

    logic signed [X_W-1:0] n_max_all, n_min_all, n_max_high, n_min_high;
    logic signed [X_W-1:0] n_max_low, n_min_low;
    logic                  n_seen_high, n_seen_low;
    logic [WSUM_W-1:0]     n_wsum;
    logic [WYSUM_W-1:0]    n_wysum;
    logic [CNT_W-1:0]      n_count;

    logic                  skip_hit, keep, high;
    logic [WSUM_W:0]       wsum_add;
    logic [PROD_W-1:0]     prod;
    logic [WYSUM_W:0]      wysum_add;
    logic signed [X_W-1:0] x;
    logic                  y_var, x_var;

    assign x        = i_sample.x;
    assign skip_hit = !i_skip_index[SKIP_W-1] && (i_skip_index[IDX_W-1:0] == i_sample.index);
    assign keep     = !skip_hit && (i_sample.weight != '0);
    // High class is y at or above one half, which is bit 14 or above in Q1.15.
    assign high     = i_sample.y[Y_W-1] || i_sample.y[Y_W-2];
    assign prod     = i_sample.weight * i_sample.y;
    assign wsum_add = {1'b0, r_wsum} + {{(WSUM_W + 1 - WT_W){1'b0}}, i_sample.weight};
    assign wysum_add = {1'b0, r_wysum} + {{(WYSUM_W + 1 - PROD_W){1'b0}}, prod};

    always_comb begin
        n_max_all   = r_max_all;
        n_min_all   = r_min_all;
        n_max_high  = r_max_high;
        n_min_high  = r_min_high;
        n_max_low   = r_max_low;
        n_min_low   = r_min_low;
        n_seen_high = r_seen_high;
        n_seen_low  = r_seen_low;
        n_wsum      = r_wsum;
        n_wysum     = r_wysum;
        n_count     = r_count;
        if (keep) begin
            if (r_count == '0) begin
                n_max_all = x;
                n_min_all = x;
            end else begin
                if (x > r_max_all) n_max_all = x;
                if (x < r_min_all) n_min_all = x;
            end
            n_wsum  = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
            n_wysum = wysum_add[WYSUM_W] ? '1 : wysum_add[WYSUM_W-1:0];
            if (r_count != '1) n_count = r_count + 1'b1;
            if (high) begin
                n_seen_high = 1'b1;
                if (!r_seen_high) begin
                    n_max_high = x;
                    n_min_high = x;
                end else begin
                    if (x > r_max_high) n_max_high = x;
                    if (x < r_min_high) n_min_high = x;
                end
            end else begin
                n_seen_low = 1'b1;
                if (!r_seen_low) begin
                    n_max_low = x;
                    n_min_low = x;
                end else begin
                    if (x > r_max_low) n_max_low = x;
                    if (x < r_min_low) n_min_low = x;
                end
            end
        end
    end

    assign y_var = (n_count > CNT_W'(1)) && n_seen_low && n_seen_high;
    assign x_var = (n_count > CNT_W'(1)) && (n_min_all < n_max_all);

    always_comb begin
        o_summary.max_all        = n_max_all;
        o_summary.min_all        = n_min_all;
        o_summary.saw_high       = n_seen_high;
        o_summary.max_high       = n_max_high;
        o_summary.min_high       = n_min_high;
        o_summary.saw_low        = n_seen_low;
        o_summary.max_low        = n_max_low;
        o_summary.min_low        = n_min_low;
        o_summary.weight_sum     = n_wsum;
        o_summary.weighted_y_sum = n_wysum;
        o_summary.point_count    = n_count;
        priority if (!y_var) begin
            o_summary.separable = 1'b1;
        end else if (!x_var) begin
            o_summary.separable = 1'b0;
        end else begin
            o_summary.separable = (n_min_high > n_max_low) || (n_min_low > n_max_high);
        end
    end

    // The closing beat hands its summary out and starts a fresh window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_sample.last)) begin
            r_max_all   <= '0;
            r_min_all   <= '0;
            r_max_high  <= '0;
            r_min_high  <= '0;
            r_max_low   <= '0;
            r_min_low   <= '0;
            r_seen_high <= 1'b0;
            r_seen_low  <= 1'b0;
            r_wsum      <= '0;
            r_wysum     <= '0;
            r_count     <= '0;
        end else if (i_en) begin
            r_max_all   <= n_max_all;
            r_min_all   <= n_min_all;
            r_max_high  <= n_max_high;
            r_min_high  <= n_min_high;
            r_max_low   <= n_max_low;
            r_min_low   <= n_min_low;
            r_seen_high <= n_seen_high;
            r_seen_low  <= n_seen_low;
            r_wsum      <= n_wsum;
            r_wysum     <= n_wysum;
            r_count     <= n_count;
        end
    end

endmodule

FILE: rtl/wwcs_out_reg.sv
// Result register of the summary stream with its valid flag.
// Depends on wwcs_pkg; loaded by the top level when a window closes.
module wwcs_out_reg
    import wwcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_summary i_summary,
    input  logic     i_ready,
    output logic     o_valid,
    output t_summary o_summary
);

    logic     r_valid;
    t_summary r_summary;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_summary <= i_summary;
        end
    end

    assign o_valid   = r_valid;
    assign o_summary = r_summary;

endmodule

FILE: rtl/weighted_window_class_summary_top.sv
// Weighted window class summary: summarizes a window of weighted points.
// Input stream carries one point per beat; tlast closes the window and
// produces one summary beat on the output stream.
// A point is registered at the input and then folded into the running state;
// the edge that folds a closing point also loads its summary into the output
// register, which raises m_axis_tvalid.
// Throughput: one point per cycle while no closing point waits on a pending
// summary. The running min/max and the one 16x16 multiply-accumulate are
// combinational between the input register and the state registers.
// Reset (synchronous, active low) clears the window state, empties both
// registers and sets skip_index to -1.
// When the output receiver stalls with a summary pending, non-closing points
// keep flowing; a second closing point waits in the input register and
// s_axis_tready drops until the pending summary is taken. The user writes
// skip_index via i_cfg_we/i_cfg_wdata only while idle; the block does not enforce it.
module weighted_window_class_summary_top
    import wwcs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SKIP_W-1:0]      i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_x[15:0], sample_y[31:16], sample_weight[47:32], item_index[59:48], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // max_all[15:0], min_all[31:16], saw_high_class[32], max_high[48:33],
    // min_high[64:49], saw_low_class[65], max_low[81:66], min_low[97:82],
    // weight_sum[125:98], weighted_y_sum[168:126], point_count[181:169],
    // separable[182], zero fill[183]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    `include "weighted_window_class_summary_top_macros.svh"

    logic              r_in_valid;
    t_sample           r_in;
    logic [SKIP_W-1:0] r_skip_index;
    logic              in_adv, out_free, in_acc;
    t_summary          summary_next, summary_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_index <= SKIP_NONE;
        end else if (i_cfg_we) begin
            r_skip_index <= i_cfg_wdata;
        end
    end

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign in_adv        = r_in_valid && (!r_in.last || out_free);
    assign s_axis_tready = !r_in_valid || in_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.x      <= s_axis_tdata[15:0];
            r_in.y      <= s_axis_tdata[31:16];
            r_in.weight <= s_axis_tdata[47:32];
            r_in.index  <= s_axis_tdata[59:48];
            r_in.last   <= s_axis_tlast;
        end
    end

    wwcs_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_adv),
        .i_sample     (r_in),
        .i_skip_index (r_skip_index),
        .o_summary    (summary_next)
    );

    wwcs_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_adv && r_in.last),
        .i_summary (summary_next),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_summary (summary_out)
    );

    assign m_axis_tdata = {1'b0,
                           summary_out.separable,
                           summary_out.point_count,
                           summary_out.weighted_y_sum,
                           summary_out.weight_sum,
                           summary_out.min_low,
                           summary_out.max_low,
                           summary_out.saw_low,
                           summary_out.min_high,
                           summary_out.max_high,
                           summary_out.saw_high,
                           summary_out.min_all,
                           summary_out.max_all};

    // A summary only appears after a closing point left the input register.
    `WWCS_ASSERT_IMPL(a_out_from_last, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(in_adv && r_in.last))
    // A closing point never overwrites a summary that is still pending.
    `WWCS_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, in_adv && r_in.last && m_axis_tvalid, m_axis_tready)
    // An empty window shows neither class.
    `WWCS_ASSERT_IMPL(a_empty_no_class, i_clk, i_rst_n, m_axis_tvalid && (summary_out.point_count == '0), !summary_out.saw_high && !summary_out.saw_low)
    // With fewer than two classes present the window is always separable.
    `WWCS_ASSERT_IMPL(a_one_class_sep, i_clk, i_rst_n, m_axis_tvalid && !(summary_out.saw_high && summary_out.saw_low), summary_out.separable)

endmodule

FILE: sim/tb_weighted_window_class_summary_top.sv
// Self-checking testbench for weighted_window_class_summary_top.
// Drives random and directed windows of points and checks every summary beat
// against a predictor built into a small scoreboard class; needs wwcs_pkg.
module tb_weighted_window_class_summary_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wwcs_pkg::*;

    localparam int HALF_Y       = 16384;
    localparam longint WSUM_CAP  = 64'h0FFF_FFFF;
    localparam longint WYSUM_CAP = 64'h7FF_FFFF_FFFF;
    localparam int COUNT_CAP    = 8191;
    localparam int SETTLE       = 4;
    localparam int PHASE_POINTS = 85;

    class window_summary_board;
        logic signed [SKIP_W-1:0] skip_reg;
        logic signed [X_W-1:0] max_all, min_all, max_high, min_high, max_low, min_low;
        bit seen_high, seen_low;
        longint unsigned wsum, wysum;
        int kept;
        t_summary summary_q[$];
        int mismatch_count;

        function new();
            skip_reg = SKIP_NONE;
            mismatch_count = 0;
            clear();
        endfunction

        function void clear();
            max_all = 0; min_all = 0;
            max_high = 0; min_high = 0;
            max_low = 0; min_low = 0;
            seen_high = 0; seen_low = 0;
            wsum = 0; wysum = 0; kept = 0;
        endfunction

        // Folds one accepted point into the running window and queues the
        // summary when the point closes the window.
        function void note_point(t_sample p);
            t_summary s;
            bit y_var, x_var;
            if (int'(p.index) != int'(skip_reg) && p.weight != 0) begin
                if (kept == 0) begin
                    max_all = p.x;
                    min_all = p.x;
                end else begin
                    if (p.x > max_all) max_all = p.x;
                    if (p.x < min_all) min_all = p.x;
                end
                wsum = wsum + p.weight;
                if (wsum > WSUM_CAP) wsum = WSUM_CAP;
                wysum = wysum + 64'(p.weight) * 64'(p.y);
                if (wysum > WYSUM_CAP) wysum = WYSUM_CAP;
                if (kept < COUNT_CAP) kept++;
                if (p.y >= HALF_Y) begin
                    if (!seen_high) begin
                        seen_high = 1;
                        max_high = p.x;
                        min_high = p.x;
                    end else begin
                        if (p.x > max_high) max_high = p.x;
                        if (p.x < min_high) min_high = p.x;
                    end
                end else begin
                    if (!seen_low) begin
                        seen_low = 1;
                        max_low = p.x;
                        min_low = p.x;
                    end else begin
                        if (p.x > max_low) max_low = p.x;
                        if (p.x < min_low) min_low = p.x;
                    end
                end
            end
            if (p.last) begin
                y_var = kept > 1 && seen_low && seen_high;
                x_var = kept > 1 && min_all < max_all;
                s.max_all        = max_all;
                s.min_all        = min_all;
                s.saw_high       = seen_high;
                s.max_high       = max_high;
                s.min_high       = min_high;
                s.saw_low        = seen_low;
                s.max_low        = max_low;
                s.min_low        = min_low;
                s.weight_sum     = wsum[WSUM_W-1:0];
                s.weighted_y_sum = wysum[WYSUM_W-1:0];
                s.point_count    = kept[CNT_W-1:0];
                if (!y_var)
                    s.separable = 1'b1;
                else if (!x_var)
                    s.separable = 1'b0;
                else
                    s.separable = (min_high > max_low) || (min_low > max_high);
                summary_q.push_back(s);
                clear();
            end
        endfunction

        function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
                mismatch_count++;
            end
        endfunction

        function void check_summary(logic [OUT_TDATA_W-1:0] d);
            t_summary e;
            if (summary_q.size() == 0) begin
                $display("%0t: summary beat with nothing expected, actual %0h", $time, d);
                mismatch_count++;
                return;
            end
            e = summary_q.pop_front();
            // Signed fields are compared as raw bits, without sign extension.
            compare("max_all", $unsigned(e.max_all), d[15:0]);
            compare("min_all", $unsigned(e.min_all), d[31:16]);
            compare("saw_high_class", e.saw_high, d[32]);
            compare("max_high", $unsigned(e.max_high), d[48:33]);
            compare("min_high", $unsigned(e.min_high), d[64:49]);
            compare("saw_low_class", e.saw_low, d[65]);
            compare("max_low", $unsigned(e.max_low), d[81:66]);
            compare("min_low", $unsigned(e.min_low), d[97:82]);
            compare("weight_sum", e.weight_sum, d[125:98]);
            compare("weighted_y_sum", e.weighted_y_sum, d[168:126]);
            compare("point_count", e.point_count, d[181:169]);
            compare("separable", e.separable, d[182]);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [SKIP_W-1:0]      i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    window_summary_board board = new();
    bit idle_on = 1'b1;

    weighted_window_class_summary_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_point('{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                                   weight: s_axis_tdata[47:32],
                                   index: s_axis_tdata[59:48], last: s_axis_tlast});
            end
            if (m_axis_tvalid && m_axis_tready)
                board.check_summary(m_axis_tdata);
        end
    end

    // Output side: a random stall, while idle_on is set, before each summary beat is taken.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Starts and ends just after a falling edge. tvalid stays high after the
    // beat so that a back-to-back point keeps it high without a dip.
    task automatic send_point(input int x, input int y, input int w, input int idx,
                              input bit last);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, idx[IDX_W-1:0], w[WT_W-1:0], y[Y_W-1:0], x[X_W-1:0]};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (board.summary_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_skip(input int v);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v[SKIP_W-1:0];
        board.skip_reg = v[SKIP_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One window with random content. The x values of the two classes are
    // drawn from bands that are apart, overlapping, equal or fully random,
    // so that every outcome of the separability test shows up.
    task automatic random_window(output int len);
        int xmode, spread, base_high, base_low, start, x, y, w, idx;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        xmode = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
            0: spread = 0;
            1: spread = 7;
            default: spread = 1000;
        endcase
        base_high = int'($urandom_range(0, 65535 - spread)) - 32768;
        case (xmode)
            1: base_low = int'($urandom_range(0, 65535 - spread)) - 32768;
            2: base_low = base_high;
            default: base_low = base_high + spread / 2;
        endcase
        start = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4095);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: y = $urandom_range(0, HALF_Y - 1);
                4, 5, 6, 7: y = $urandom_range(HALF_Y, 32768);
                8: y = HALF_Y - 1 + $urandom_range(0, 1);
                default: y = $urandom_range(0, 65535);
            endcase
            if (xmode == 0)
                x = $urandom_range(0, 65535);
            else
                x = ((y >= HALF_Y) ? base_high : base_low) + $urandom_range(0, spread);
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = 65535;
                2: w = $urandom_range(1, 255);
                default: w = $urandom_range(1, 65535);
            endcase
            case ($urandom_range(0, 7))
                0: idx = board.skip_reg[IDX_W-1:0];
                1: idx = $urandom_range(0, 4095);
                default: idx = (start + i) % 4096;
            endcase
            send_point(x, y, w, idx, i == len - 1);
        end
    endtask

    initial begin
        int phase_skips[7] = '{2, 4095, -4096, 0, -2, 7, -1};
        int sent, len;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Window whose only point has zero weight: empty summary.
        send_point(1234, 20000, 0, 0, 1);
        // Extremes of every field, y exactly one half counts as high.
        send_point(-32768, 0, 65535, 0, 0);
        send_point(32767, 32768, 65535, 1, 0);
        send_point(0, HALF_Y, 1, 2, 0);
        send_point(5, HALF_Y - 1, 256, 4095, 1);
        // y above one, and x constant across both classes.
        send_point(100, 65535, 65535, 3, 0);
        send_point(100, 0, 1, 4, 1);
        // Low class entirely above the high class.
        send_point(300, 100, 10, 0, 0);
        send_point(400, 200, 10, 1, 0);
        send_point(-5, 30000, 10, 2, 0);
        send_point(10, 20000, 10, 3, 1);
        // Classes overlap.
        send_point(0, 20000, 3, 0, 0);
        send_point(50, 20000, 3, 1, 0);
        send_point(25, 10, 3, 2, 1);
        // Closing point dropped for zero weight.
        send_point(7, 100, 3, 0, 0);
        send_point(9, 100, 0, 1, 1);
        // One class only.
        send_point(-20, 17000, 40, 0, 0);
        send_point(20, 18000, 40, 1, 0);
        send_point(0, 32768, 40, 2, 1);

        foreach (phase_skips[k]) begin
            write_skip(phase_skips[k]);
            idle_on = ($urandom_range(0, 3) != 0);
            if (k == 0) begin
                // Closing point dropped by its index.
                send_point(10, 100, 5, 0, 0);
                send_point(20, 20000, 5, 1, 0);
                send_point(30, 30000, 5, 2, 1);
            end
            sent = 0;
            while (sent < PHASE_POINTS) begin
                random_window(len);
                sent += len;
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (board.mismatch_count == 0 && board.summary_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
